// ===== hw/rtl/cfpd_pkg.sv =====
package cfpd_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam int MIN_BODY_LEN = 5;
	localparam int FRAME_CAP = 512;
	localparam int FRAME_OVERHEAD = 6;
	localparam int BODY_OFFSET = 4;
	localparam int PAYLOAD_OFFSET = 9;
	localparam int CHUNK_BYTES = 8;

	localparam logic [1:0] REG_MAGIC_HIGH = 2'd0;
	localparam logic [1:0] REG_MAGIC_LOW_REQUEST = 2'd1;
	localparam logic [1:0] REG_MAGIC_LOW_RESPONSE = 2'd2;
	localparam logic [1:0] REG_MAX_FRAME_TOTAL = 2'd3;

	typedef logic [7:0] byte_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input byte_t data);
		logic [15:0] crc;
		crc = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (crc[15]) begin
				crc = {crc[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc = {crc[14:0], 1'b0};
			end
		end
		return crc;
	endfunction

endpackage

// ===== hw/rtl/cfpd_intf.sv =====
interface cfpd_in_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfpd_out_if;
	logic valid;
	logic ready;
	logic [7:0] magic_low;
	logic [15:0] sync_word;
	logic [7:0] sequence_res;
	logic [7:0] direction;
	logic [7:0] command;
	logic [8:0] payload_len;
	logic [5:0] chunk_index;
	logic [63:0] chunk_data;
	logic [3:0] chunk_bytes;
	logic last_chunk;
	modport source (output valid, output magic_low, output sync_word, output sequence_res,
		output direction, output command, output payload_len, output chunk_index,
		output chunk_data, output chunk_bytes, output last_chunk, input ready);
	modport sink (input valid, input magic_low, input sync_word, input sequence_res,
		input direction, input command, input payload_len, input chunk_index,
		input chunk_data, input chunk_bytes, input last_chunk, output ready);
endinterface

// ===== hw/rtl/cfpd_ram.sv =====
module cfpd_ram #(
	parameter int DEPTH = 512,
	parameter int AW = 9
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input cfpd_pkg::byte_t wdata,
	input logic [AW-1:0] raddr,
	output cfpd_pkg::byte_t rdata
);
	import cfpd_pkg::*;

	byte_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/crc_framed_packet_deframer_top.sv =====
// Channel | Direction | Payload
// rx      | sink      | rx_byte
// res     | source    | frame header fields and one payload chunk
// cfg     | write     | cfg_idx selects the register, cfg_wdata carries the value
//
// The sync search, the CRC over the body and the building of results all go through the
// single read port of the receive buffer. Reset clears the buffer pointers and
// registers, not the buffer. A stalled result holds the sequencer; no new byte is
// taken until the search ends.
module crc_framed_packet_deframer_top #(
	parameter int BUFFER_BYTES = 512
) (
	input logic clk,
	input logic arst_n,
	cfpd_in_if.sink rx,
	cfpd_out_if.source res,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [9:0] cfg_wdata
);
	import cfpd_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int FW = $clog2(BUFFER_BYTES + 1);
	localparam int CAP = (BUFFER_BYTES < FRAME_CAP) ? BUFFER_BYTES : FRAME_CAP;

	typedef enum logic [4:0] {
		S_IDLE, S_M0, S_M1, S_MCHK, S_L0, S_L1, S_LCHK, S_CRD, S_CUP,
		S_W0, S_W1, S_WCHK, S_EPREP, S_ERD, S_ECAP, S_EOUT
	} state_t;

	state_t state_q;
	logic [AW-1:0] head_q, off_q, cnt_q, len_q;
	logic [FW-1:0] fill_q;
	logic [5:0] k_q;
	logic [3:0] nb_q;
	logic last_q;
	byte_t tmp_q, mlow_q, seq_q, dir_q, cmd_q;
	logic [15:0] sync_q, crc_q;
	logic [63:0] data_q;
	byte_t mh_q, mreq_q, mrsp_q;
	logic [9:0] max_q;
	logic out_valid_q;

	logic [AW-1:0] raddr, waddr;
	logic we;
	byte_t rdata;
	logic [16:0] lim, len_full, total_full;
	logic [AW:0] plen, rem, k8;
	logic out_free;

	function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
		if (v >= (AW+1)'(BUFFER_BYTES)) begin
			return AW'(v - (AW+1)'(BUFFER_BYTES));
		end
		return AW'(v);
	endfunction

	assign raddr = wrap({1'b0, head_q} + {1'b0, off_q});
	assign we = rx.valid && rx.ready;
	assign waddr = (fill_q == FW'(BUFFER_BYTES)) ? head_q
		: wrap({1'b0, head_q} + (AW+1)'(fill_q));

	cfpd_ram #(.DEPTH(BUFFER_BYTES), .AW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(rx.rx_byte), .raddr(raddr), .rdata(rdata)
	);

	assign lim = (17'(max_q) > 17'(CAP)) ? 17'(CAP) : 17'(max_q);
	assign len_full = {1'b0, rdata, tmp_q};
	assign total_full = len_full + 17'(FRAME_OVERHEAD);
	assign plen = (AW+1)'(len_q) - (AW+1)'(MIN_BODY_LEN);
	assign k8 = (AW+1)'({k_q, 3'b000});
	assign rem = plen - k8;
	assign out_free = !out_valid_q || res.ready;

	assign rx.ready = (state_q == S_IDLE);
	assign res.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mh_q <= '0;
			mreq_q <= '0;
			mrsp_q <= '0;
			max_q <= 10'(FRAME_CAP);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAGIC_HIGH: mh_q <= cfg_wdata[7:0];
				REG_MAGIC_LOW_REQUEST: mreq_q <= cfg_wdata[7:0];
				REG_MAGIC_LOW_RESPONSE: mrsp_q <= cfg_wdata[7:0];
				REG_MAX_FRAME_TOTAL: max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			fill_q <= '0;
			off_q <= '0;
			cnt_q <= '0;
			len_q <= '0;
			k_q <= '0;
			nb_q <= '0;
			last_q <= 1'b0;
			tmp_q <= '0;
			mlow_q <= '0;
			seq_q <= '0;
			dir_q <= '0;
			cmd_q <= '0;
			sync_q <= '0;
			crc_q <= '0;
			data_q <= '0;
			out_valid_q <= 1'b0;
			res.magic_low <= '0;
			res.sync_word <= '0;
			res.sequence_res <= '0;
			res.direction <= '0;
			res.command <= '0;
			res.payload_len <= '0;
			res.chunk_index <= '0;
			res.chunk_data <= '0;
			res.chunk_bytes <= '0;
			res.last_chunk <= 1'b0;
		end else begin
			if (out_valid_q && res.ready && state_q != S_EOUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (we) begin
						if (fill_q == FW'(BUFFER_BYTES)) begin
							head_q <= wrap({1'b0, head_q} + (AW+1)'(1));
						end else begin
							fill_q <= fill_q + FW'(1);
						end
						off_q <= '0;
						state_q <= S_M0;
					end
				end
				S_M0: begin
					if (fill_q < FW'(2)) begin
						state_q <= S_IDLE;
					end else begin
						off_q <= AW'(1);
						state_q <= S_M1;
					end
				end
				S_M1: begin
					tmp_q <= rdata;
					off_q <= AW'(2);
					state_q <= S_MCHK;
				end
				S_MCHK: begin
					if (tmp_q == mh_q && (rdata == mreq_q || rdata == mrsp_q)) begin
						mlow_q <= rdata;
						state_q <= (fill_q < FW'(4)) ? S_IDLE : S_L0;
					end else begin
						head_q <= wrap({1'b0, head_q} + (AW+1)'(1));
						fill_q <= fill_q - FW'(1);
						off_q <= '0;
						state_q <= S_M0;
					end
				end
				S_L0: begin
					off_q <= AW'(3);
					state_q <= S_L1;
				end
				S_L1: begin
					tmp_q <= rdata;
					state_q <= S_LCHK;
				end
				S_LCHK: begin
					if (len_full < 17'(MIN_BODY_LEN) || total_full > lim) begin
						head_q <= wrap({1'b0, head_q} + (AW+1)'(1));
						fill_q <= fill_q - FW'(1);
						off_q <= '0;
						state_q <= S_M0;
					end else if (17'(fill_q) < total_full) begin
						state_q <= S_IDLE;
					end else begin
						len_q <= AW'(len_full);
						off_q <= AW'(BODY_OFFSET);
						cnt_q <= '0;
						crc_q <= '0;
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					state_q <= S_CUP;
				end
				S_CUP: begin
					crc_q <= crc16_byte(crc_q, rdata);
					if (cnt_q == AW'(0)) sync_q[15:8] <= rdata;
					if (cnt_q == AW'(1)) sync_q[7:0] <= rdata;
					if (cnt_q == AW'(2)) seq_q <= rdata;
					if (cnt_q == AW'(3)) dir_q <= rdata;
					if (cnt_q == AW'(4)) cmd_q <= rdata;
					cnt_q <= cnt_q + AW'(1);
					off_q <= off_q + AW'(1);
					state_q <= (cnt_q + AW'(1) == len_q) ? S_W0 : S_CRD;
				end
				S_W0: begin
					off_q <= off_q + AW'(1);
					state_q <= S_W1;
				end
				S_W1: begin
					tmp_q <= rdata;
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if ({rdata, tmp_q} != crc_q) begin
						head_q <= wrap({1'b0, head_q} + (AW+1)'(1));
						fill_q <= fill_q - FW'(1);
						off_q <= '0;
						state_q <= S_M0;
					end else begin
						k_q <= '0;
						off_q <= AW'(PAYLOAD_OFFSET);
						state_q <= S_EPREP;
					end
				end
				S_EPREP: begin
					data_q <= '0;
					cnt_q <= '0;
					last_q <= (rem <= (AW+1)'(CHUNK_BYTES));
					if (plen == '0) begin
						nb_q <= '0;
						state_q <= S_EOUT;
					end else begin
						nb_q <= (rem > (AW+1)'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : 4'(rem);
						state_q <= S_ERD;
					end
				end
				S_ERD: begin
					off_q <= off_q + AW'(1);
					state_q <= S_ECAP;
				end
				S_ECAP: begin
					data_q[8*cnt_q[2:0] +: 8] <= rdata;
					cnt_q <= cnt_q + AW'(1);
					state_q <= (4'(cnt_q + AW'(1)) == nb_q) ? S_EOUT : S_ERD;
				end
				S_EOUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res.magic_low <= mlow_q;
						res.sync_word <= sync_q;
						res.sequence_res <= seq_q;
						res.direction <= dir_q;
						res.command <= cmd_q;
						res.payload_len <= 9'(plen);
						res.chunk_index <= k_q;
						res.chunk_data <= data_q;
						res.chunk_bytes <= nb_q;
						res.last_chunk <= last_q;
						if (last_q) begin
							head_q <= wrap({1'b0, head_q} + (AW+1)'(len_q) + (AW+1)'(FRAME_OVERHEAD));
							fill_q <= fill_q - FW'(len_q) - FW'(FRAME_OVERHEAD);
							off_q <= '0;
							state_q <= S_M0;
						end else begin
							k_q <= k_q + 6'd1;
							state_q <= S_EPREP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FW'(BUFFER_BYTES))
		else $error("buffer fill exceeds depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.chunk_bytes == 4'd0 |-> res.payload_len == 9'd0 && res.last_chunk)
		else $error("empty chunk outside an empty payload");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EOUT && out_free |=> res.valid)
		else $error("result not presented after load");

endmodule

// ===== sim/tb_crc_framed_packet_deframer_top.sv =====
`timescale 1ns / 1ps

module tb_crc_framed_packet_deframer_top;
	import cfpd_pkg::*;

	typedef struct packed {
		logic [7:0] magic_low;
		logic [15:0] sync_word;
		logic [7:0] sequence_res;
		logic [7:0] direction;
		logic [7:0] command;
		logic [8:0] payload_len;
		logic [5:0] chunk_index;
		logic [63:0] chunk_data;
		logic [3:0] chunk_bytes;
		logic last_chunk;
	} chunk_t;

	typedef struct {
		byte_t rx_byte;
		bit typed;
		chunk_t chunk;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [9:0] cfg_wdata;

	cfpd_in_if rx ();
	cfpd_out_if res ();

	crc_framed_packet_deframer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx.sink),
		.res(res.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	byte_t rx_fifo[$];
	chunk_t chunk_q[$];
	byte_t magic_hi, magic_req, magic_resp;
	int frame_limit;
	int errors;
	int bytes_sent;
	int chunks_seen;
	int frames_seen;
	int idle_pct;
	int stall_pct;
	bit hold_go;
	row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [15:0] crc_over(int first, int count);
		logic [15:0] crc;
		crc = 16'h0000;
		for (int i = 0; i < count; i++) begin
			crc = crc ^ {rx_fifo[first + i], 8'h00};
			for (int b = 0; b < 8; b++) begin
				if (crc[15]) begin
					crc = {crc[14:0], 1'b0} ^ 16'h1021;
				end else begin
					crc = {crc[14:0], 1'b0};
				end
			end
		end
		return crc;
	endfunction

	function automatic bit pair_at(int pos);
		return rx_fifo[pos] == magic_hi &&
			(rx_fifo[pos + 1] == magic_req || rx_fifo[pos + 1] == magic_resp);
	endfunction

	function automatic void drop_bytes(int n);
		for (int i = 0; i < n && rx_fifo.size() > 0; i++) begin
			void'(rx_fifo.pop_front());
		end
	endfunction

	// Runs the deframer for one received byte and queues the chunks it releases.
	function automatic void deframe_byte(byte_t b);
		int pos, len, total, plen, nres, nb;
		logic [63:0] data;
		chunk_t c;
		if (rx_fifo.size() >= 512) begin
			void'(rx_fifo.pop_front());
		end
		rx_fifo.insert(rx_fifo.size(), b);
		forever begin
			pos = 0;
			while (pos + 1 < rx_fifo.size() && !pair_at(pos)) begin
				pos++;
			end
			drop_bytes(pos);
			if (rx_fifo.size() < 4) begin
				break;
			end
			len = int'(rx_fifo[2]) | (int'(rx_fifo[3]) << 8);
			total = len + 6;
			if (len < 5 || total > frame_limit) begin
				drop_bytes(1);
				continue;
			end
			if (rx_fifo.size() < total) begin
				break;
			end
			if (crc_over(4, len) != {rx_fifo[5 + len], rx_fifo[4 + len]}) begin
				drop_bytes(1);
				continue;
			end
			plen = len - 5;
			nres = (plen == 0) ? 1 : (plen + 7) / 8;
			for (int k = 0; k < nres; k++) begin
				nb = plen - k * 8;
				if (nb > 8) begin
					nb = 8;
				end
				data = 64'd0;
				for (int j = 0; j < nb; j++) begin
					data[8 * j +: 8] = rx_fifo[9 + k * 8 + j];
				end
				c.magic_low = rx_fifo[1];
				c.sync_word = {rx_fifo[4], rx_fifo[5]};
				c.sequence_res = rx_fifo[6];
				c.direction = rx_fifo[7];
				c.command = rx_fifo[8];
				c.payload_len = plen[8:0];
				c.chunk_index = k[5:0];
				c.chunk_data = data;
				c.chunk_bytes = nb[3:0];
				c.last_chunk = (k + 1 == nres);
				chunk_q.insert(chunk_q.size(), c);
			end
			drop_bytes(total);
		end
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	task automatic check_chunk(chunk_t e, chunk_t a);
		check_field("magic_low", 64'(e.magic_low), 64'(a.magic_low));
		check_field("sync_word", 64'(e.sync_word), 64'(a.sync_word));
		check_field("sequence_res", 64'(e.sequence_res), 64'(a.sequence_res));
		check_field("direction", 64'(e.direction), 64'(a.direction));
		check_field("command", 64'(e.command), 64'(a.command));
		check_field("payload_len", 64'(e.payload_len), 64'(a.payload_len));
		check_field("chunk_index", 64'(e.chunk_index), 64'(a.chunk_index));
		check_field("chunk_data", e.chunk_data, a.chunk_data);
		check_field("chunk_bytes", 64'(e.chunk_bytes), 64'(a.chunk_bytes));
		check_field("last_chunk", 64'(e.last_chunk), 64'(a.last_chunk));
	endtask

	always @(posedge clk) begin
		chunk_t got;
		if (arst_n && res.valid && res.ready) begin
			got.magic_low = res.magic_low;
			got.sync_word = res.sync_word;
			got.sequence_res = res.sequence_res;
			got.direction = res.direction;
			got.command = res.command;
			got.payload_len = res.payload_len;
			got.chunk_index = res.chunk_index;
			got.chunk_data = res.chunk_data;
			got.chunk_bytes = res.chunk_bytes;
			got.last_chunk = res.last_chunk;
			chunks_seen++;
			if (got.last_chunk) begin
				frames_seen++;
			end
			if (chunk_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %0h", $time, got);
				errors++;
			end else begin
				check_chunk(chunk_q.pop_front(), got);
			end
		end
	end

	always @(posedge clk) begin
		int hold_cnt;
		bit hold_done;
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			hold_cnt = 4000;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_byte(byte_t b);
		while ($urandom_range(99) < idle_pct) begin
			rx.valid <= 1'b0;
			@(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		do begin
			@(posedge clk);
		end while (!rx.ready);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic drain(int tail);
		rx.valid <= 1'b0;
		while (chunk_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MAGIC_HIGH: magic_hi = value[7:0];
			REG_MAGIC_LOW_REQUEST: magic_req = value[7:0];
			REG_MAGIC_LOW_RESPONSE: magic_resp = value[7:0];
			REG_MAX_FRAME_TOTAL: frame_limit = (int'(value) > FRAME_CAP) ? FRAME_CAP
				: int'(value);
			default: ;
		endcase
	endtask

	task automatic set_magic(byte_t hi, byte_t req, byte_t resp, logic [9:0] max_total);
		drain(6000);
		write_reg(REG_MAGIC_HIGH, {2'b00, hi});
		write_reg(REG_MAGIC_LOW_REQUEST, {2'b00, req});
		write_reg(REG_MAGIC_LOW_RESPONSE, {2'b00, resp});
		write_reg(REG_MAX_FRAME_TOTAL, max_total);
	endtask

	// Builds one frame; mode 0 is good, 1 has a bad CRC, 2 a bad length, 3 is cut short.
	task automatic push_frame(ref byte_t q[$], input int plen, input int mode);
		byte_t body[$];
		int len;
		logic [15:0] crc;
		len = plen + 5;
		for (int i = 0; i < len; i++) begin
			body.insert(body.size(), 8'($urandom_range(255)));
		end
		crc = 16'h0000;
		foreach (body[i]) begin
			crc = crc ^ {body[i], 8'h00};
			for (int b = 0; b < 8; b++) begin
				crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
			end
		end
		if (mode == 1) begin
			crc = crc ^ (16'h1 << $urandom_range(15));
		end
		if (mode == 2) begin
			len = $urandom_range(1) ? $urandom_range(4) : frame_limit - 5 + $urandom_range(40);
		end
		q.insert(q.size(), magic_hi);
		q.insert(q.size(), $urandom_range(1) ? magic_req : magic_resp);
		q.insert(q.size(), len[7:0]);
		q.insert(q.size(), len[15:8]);
		if (mode == 3) begin
			repeat ($urandom_range(body.size() - 1)) q.insert(q.size(), body.pop_front());
		end else begin
			foreach (body[i]) q.insert(q.size(), body[i]);
			q.insert(q.size(), crc[7:0]);
			q.insert(q.size(), crc[15:8]);
		end
	endtask

	task automatic random_phase(int items);
		byte_t q[$];
		int r, plen, sent;
		sent = 0;
		while (sent < items) begin
			q.delete();
			r = $urandom_range(99);
			plen = ($urandom_range(19) == 0)
				? $urandom_range((frame_limit - 11 < 100) ? frame_limit - 11 : 100)
				: $urandom_range((frame_limit - 11 < 24) ? frame_limit - 11 : 24);
			if (r < 65) begin
				push_frame(q, plen, 0);
			end else if (r < 75) begin
				push_frame(q, plen, 1);
			end else if (r < 83) begin
				push_frame(q, plen, 2);
			end else if (r < 90) begin
				push_frame(q, plen, 3);
			end else begin
				repeat ($urandom_range(6, 1)) q.insert(q.size(), 8'($urandom_range(255)));
			end
			foreach (q[i]) send_byte(q[i]);
			sent += q.size();
		end
	endtask

	task automatic directed_part();
		row_t row;
		chunk_t zero_frame;
		byte_t seq[$];
		zero_frame = '0;
		zero_frame.last_chunk = 1'b1;
		seq = '{8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h04, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h55, 8'hAA,
			8'h00, 8'h00, 8'hFF, 8'hFF};
		foreach (seq[i]) begin
			row.rx_byte = seq[i];
			row.typed = (i == 10);
			row.chunk = zero_frame;
			rows.insert(rows.size(), row);
		end
		foreach (rows[i]) begin
			send_byte(rows[i].rx_byte);
			if (rows[i].typed) begin
				if (chunk_q.size() != 1) begin
					$display("%0t: empty frame, expected 1 result actual %0d", $time,
						chunk_q.size());
					errors++;
				end else begin
					check_chunk(rows[i].chunk, chunk_q[0]);
				end
			end
		end
	endtask

	initial begin
		byte_t q[$];
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_idx = REG_MAGIC_HIGH;
		cfg_wdata = 10'd0;
		magic_hi = 8'h00;
		magic_req = 8'h00;
		magic_resp = 8'h00;
		frame_limit = 512;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_go = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();

		set_magic(8'hFF, 8'h00, 8'h80, 10'd512);
		push_frame(q, 17, 0);
		foreach (q[i]) send_byte(q[i]);
		random_phase(25);

		set_magic(8'hA5, 8'h5A, 8'h3C, 10'd11);
		idle_pct = 78;
		random_phase(20);

		set_magic(8'h00, 8'hFF, 8'h01, 10'($urandom_range(200, 20)));
		idle_pct = 0;
		stall_pct = 78;
		random_phase(25);

		set_magic(8'h55, 8'hAA, 8'hAA, 10'd1023);
		idle_pct = 18;
		stall_pct = 18;
		random_phase(25);

		// Hold off the receiver while frames keep arriving back to back.
		drain(6000);
		idle_pct = 0;
		stall_pct = 0;
		hold_go = 1'b1;
		repeat (3) begin
			q.delete();
			push_frame(q, $urandom_range(12, 9), 0);
			foreach (q[i]) send_byte(q[i]);
		end
		drain(0);
		random_phase(12);

		drain(6000);
		$display("Sent %0d bytes over five register settings; %0d chunks in %0d frames.",
			bytes_sent, chunks_seen, frames_seen);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
